/* design/sha256_pkg.sv */
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared constants, round functions and control types of the SHA-256 hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

    localparam int CHAIN_WORDS = 8;
    localparam int BLOCK_WORDS = 16;
    localparam int ROUNDS      = 64;
    localparam int LEN_WORD_HI = 14;
    localparam int LEN_WORD_LO = 15;

    localparam logic [7:0]  PAD_MARK   = 8'h80;
    localparam logic [63:0] BLOCK_BITS = 64'd512;

    localparam logic [31:0] K_ROUND [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_H [CHAIN_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // control of the round datapath
    typedef struct packed {
        logic w_shift;  // shift a loaded word into the schedule
        logic v_shift;  // shift a word into the working variables
        logic round;    // run one compression round
    } t_core_ctl;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

/* design/sha256_if.sv */
// ----------------------------------------------------------------------------
// sha256 stream interfaces
// Valid/ready channels for message bytes in and digest words out.
// ----------------------------------------------------------------------------
interface sha256_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;

    modport source (output valid, data_byte, byte_present, end_of_message, input ready);
    modport sink   (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha256_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

/* design/sha256_byte_stream_hasher.sv */
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// SHA-256 over a byte stream, digest out as eight 32-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one message byte per word (byte_present), end_of_message
//   marks the final word; a final word with byte_present low ends the
//   message with the bytes held so far. o_out returns the digest as eight
//   words, index 0 first, last_word high on index 7.
//   A byte that does not complete a block is taken while the block is idle.
//   A full block is loaded, run through 64 rounds (one round per cycle)
//   and folded into the chaining memory; no input is taken meanwhile.
//   After the final word, padding writes the rest of each padded block,
//   followed by one or two compressions; then each digest word is read,
//   loaded and held until the receiver takes it.
//   The message block lives in a 16x32 RAM, the chaining words in an 8x32
//   RAM. Input is taken only while the block is idle.
//   Reset returns the chaining words to the initial values and clears the
//   byte count and bit length. A stalled receiver holds the current digest
//   word; no input is taken until all eight words are delivered.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sha256_in_if.sink    i_in,
    sha256_out_if.source o_out
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b00000001,
        S_PAD    = 8'b00000010,
        S_LOAD   = 8'b00000100,
        S_ROUND  = 8'b00001000,
        S_FOLD   = 8'b00010000,
        S_OUT_RD = 8'b00100000,
        S_OUT_LD = 8'b01000000,
        S_OUT_WT = 8'b10000000
    } t_state;

    typedef enum logic [1:0] {
        NX_IDLE = 2'd0,
        NX_PAD  = 2'd1,
        NX_PAD2 = 2'd2,
        NX_OUT  = 2'd3
    } t_after;

    t_state      r_state;
    t_after      r_after;
    logic [5:0]  r_fill;
    logic [63:0] r_bits;
    logic [23:0] r_acc;
    logic [5:0]  r_cnt;
    logic [3:0]  r_widx;
    logic        r_final;
    logic        r_padw;
    logic        r_hinit;
    logic [2:0]  r_craddr;
    logic [31:0] r_dout;
    logic [2:0]  r_oidx;
    logic        r_ovalid;

    logic        in_acc;
    logic [5:0]  n_fill;
    logic        wb_we;
    logic [3:0]  wb_waddr;
    logic [31:0] wb_wdata;
    logic [31:0] wb_rdata;
    logic [31:0] pad_word;
    logic        ch_we;
    logic [2:0]  ch_waddr;
    logic [31:0] ch_rdata_ram;
    logic [31:0] ch_rdata;
    logic [31:0] v0;
    sha256_pkg::t_core_ctl ctl;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign n_fill     = i_in.byte_present ? r_fill + 6'd1 : r_fill;

    // chaining memory reads as the initial values until first written
    assign ch_rdata = r_hinit ? sha256_pkg::INIT_H[r_craddr] : ch_rdata_ram;

    // first padding word: held bytes, then the pad mark
    always_comb begin
        unique case (r_fill[1:0])
            2'd0: pad_word = {sha256_pkg::PAD_MARK, 24'h0};
            2'd1: pad_word = {r_acc[7:0], sha256_pkg::PAD_MARK, 16'h0};
            2'd2: pad_word = {r_acc[15:0], sha256_pkg::PAD_MARK, 8'h0};
            2'd3: pad_word = {r_acc, sha256_pkg::PAD_MARK};
            default: pad_word = '0;
        endcase
    end

    // block memory write: byte packing or padding
    always_comb begin
        wb_we    = 1'b0;
        wb_waddr = r_fill[5:2];
        wb_wdata = {r_acc, i_in.data_byte};
        if (r_state == S_IDLE) begin
            wb_we = in_acc && i_in.byte_present && (r_fill[1:0] == 2'd3);
        end else if (r_state == S_PAD) begin
            wb_we    = 1'b1;
            wb_waddr = r_widx;
            priority if (r_padw && (r_widx == r_fill[5:2])) begin
                wb_wdata = pad_word;
            end else if (r_final && (r_widx == 4'(sha256_pkg::LEN_WORD_HI))) begin
                wb_wdata = r_bits[63:32];
            end else if (r_final && (r_widx == 4'(sha256_pkg::LEN_WORD_LO))) begin
                wb_wdata = r_bits[31:0];
            end else begin
                wb_wdata = '0;
            end
        end
    end

    // chaining fold write and round datapath control
    always_comb begin
        ch_we        = (r_state == S_FOLD) && (r_cnt != 6'd0);
        ch_waddr     = r_cnt[2:0] - 3'd1;
        ctl.w_shift  = (r_state == S_LOAD) && (r_cnt != 6'd0);
        ctl.v_shift  = ((r_state == S_LOAD) && (r_cnt != 6'd0) && (r_cnt <= 6'd8))
                    || ch_we;
        ctl.round    = (r_state == S_ROUND);
    end

    // word shifted into the schedule comes from the block memory
    logic [31:0] sched_word;
    logic [31:0] var_word;
    assign sched_word = wb_rdata;
    assign var_word   = ch_rdata;

    sha256_ram #(
        .WIDTH(32),
        .DEPTH(sha256_pkg::BLOCK_WORDS)
    ) u_block_ram (
        .i_clk  (i_clk),
        .i_we   (wb_we),
        .i_waddr(wb_waddr),
        .i_wdata(wb_wdata),
        .i_raddr(r_cnt[3:0]),
        .o_rdata(wb_rdata)
    );

    sha256_ram #(
        .WIDTH(32),
        .DEPTH(sha256_pkg::CHAIN_WORDS)
    ) u_chain_ram (
        .i_clk  (i_clk),
        .i_we   (ch_we),
        .i_waddr(ch_waddr),
        .i_wdata(ch_rdata + v0),
        .i_raddr(r_cnt[2:0]),
        .o_rdata(ch_rdata_ram)
    );

    // the schedule and the variables shift together during load, so the
    // core takes separate words for each
    sha256_round u_round (
        .i_clk (i_clk),
        .i_ctl (ctl),
        .i_word(sched_word),
        .i_var (var_word),
        .i_rnd (r_cnt),
        .o_v0  (v0)
    );

    // byte packing register
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in.byte_present) begin
            r_acc <= {r_acc[15:0], i_in.data_byte};
        end
        r_craddr <= r_cnt[2:0];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_after  <= NX_IDLE;
            r_fill   <= '0;
            r_bits   <= '0;
            r_cnt    <= '0;
            r_widx   <= '0;
            r_final  <= 1'b0;
            r_padw   <= 1'b0;
            r_hinit  <= 1'b1;
            r_ovalid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_in.byte_present && (r_fill == 6'd63)) begin
                            r_fill  <= '0;
                            r_bits  <= r_bits + sha256_pkg::BLOCK_BITS;
                            r_cnt   <= '0;
                            r_after <= i_in.end_of_message ? NX_PAD : NX_IDLE;
                            r_state <= S_LOAD;
                        end else begin
                            r_fill <= n_fill;
                            if (i_in.end_of_message) begin
                                r_widx  <= n_fill[5:2];
                                r_final <= (n_fill[5:2] < 4'(sha256_pkg::LEN_WORD_HI));
                                r_padw  <= 1'b1;
                                r_state <= S_PAD;
                            end
                        end
                    end
                end
                S_PAD: begin
                    if (r_padw && (r_widx == r_fill[5:2])) begin
                        r_bits <= r_bits + {55'h0, r_fill, 3'b000};
                    end
                    if (r_widx == 4'(sha256_pkg::LEN_WORD_LO)) begin
                        r_cnt   <= '0;
                        r_after <= r_final ? NX_OUT : NX_PAD2;
                        r_state <= S_LOAD;
                    end else begin
                        r_widx <= r_widx + 4'd1;
                    end
                end
                S_LOAD: begin
                    if (r_cnt == 6'd16) begin
                        r_cnt   <= '0;
                        r_state <= S_ROUND;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_ROUND: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'(sha256_pkg::ROUNDS - 1)) begin
                        r_state <= S_FOLD;
                    end
                end
                S_FOLD: begin
                    if (r_cnt == 6'd8) begin
                        r_hinit <= 1'b0;
                        r_cnt   <= '0;
                        unique case (r_after)
                            NX_IDLE: r_state <= S_IDLE;
                            NX_PAD: begin
                                r_widx  <= '0;
                                r_final <= 1'b1;
                                r_padw  <= 1'b1;
                                r_state <= S_PAD;
                            end
                            NX_PAD2: begin
                                r_widx  <= '0;
                                r_final <= 1'b1;
                                r_padw  <= 1'b0;
                                r_state <= S_PAD;
                            end
                            NX_OUT:  r_state <= S_OUT_RD;
                            default: r_state <= S_IDLE;
                        endcase
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_OUT_RD: begin
                    r_state <= S_OUT_LD;
                end
                S_OUT_LD: begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_OUT_WT;
                end
                S_OUT_WT: begin
                    if (o_out.ready) begin
                        r_ovalid <= 1'b0;
                        if (r_cnt[2:0] == 3'd7) begin
                            r_hinit <= 1'b1;
                            r_fill  <= '0;
                            r_bits  <= '0;
                            r_cnt   <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_cnt   <= r_cnt + 6'd1;
                            r_state <= S_OUT_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // digest word register
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT_LD) begin
            r_dout <= ch_rdata;
            r_oidx <= r_cnt[2:0];
        end
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.digest_word = r_dout;
    assign o_out.word_index  = r_oidx;
    assign o_out.last_word   = (r_oidx == 3'd7);

    // input is never taken while a digest word is pending
    a_no_in_during_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("input ready while digest word pending");

    // rounds run back to back and end in the fold
    a_round_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND) |=> (r_state == S_ROUND || r_state == S_FOLD))
        else $error("round sequence broken");

    // after the last digest word the hasher is back at the initial state
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last_word)
        |=> (r_hinit && (r_fill == 6'd0) && (r_bits == 64'd0)))
        else $error("state not restored after digest");

endmodule

/* design/sha256_ram.sv */
// ----------------------------------------------------------------------------
// sha256_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sha256_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* design/sha256_round.sv */
// ----------------------------------------------------------------------------
// sha256_round
// Message schedule window and working variables, one round per cycle.
// ----------------------------------------------------------------------------
module sha256_round (
    input  logic                  i_clk,
    input  sha256_pkg::t_core_ctl i_ctl,
    input  logic [31:0]           i_word,
    input  logic [31:0]           i_var,
    input  logic [5:0]            i_rnd,
    output logic [31:0]           o_v0
);

    logic [31:0] r_w [sha256_pkg::BLOCK_WORDS];
    logic [31:0] r_v [sha256_pkg::CHAIN_WORDS];
    logic [31:0] w_next;
    logic [31:0] t1;
    logic [31:0] t2;

    // schedule expansion and round sums
    always_comb begin
        w_next = r_w[0] + sha256_pkg::small_sigma0(r_w[1]) + r_w[9]
               + sha256_pkg::small_sigma1(r_w[14]);
        t1 = r_v[7] + sha256_pkg::big_sigma1(r_v[4])
           + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
           + sha256_pkg::K_ROUND[i_rnd] + r_w[0];
        t2 = sha256_pkg::big_sigma0(r_v[0])
           + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    // schedule window: w[0] is the word of the current round
    always_ff @(posedge i_clk) begin
        if (i_ctl.w_shift || i_ctl.round) begin
            for (int i = 0; i < sha256_pkg::BLOCK_WORDS - 1; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[sha256_pkg::BLOCK_WORDS-1] <= i_ctl.w_shift ? i_word : w_next;
        end
    end

    // working variables a..h
    always_ff @(posedge i_clk) begin
        if (i_ctl.v_shift) begin
            for (int i = 0; i < sha256_pkg::CHAIN_WORDS - 1; i++) begin
                r_v[i] <= r_v[i+1];
            end
            r_v[sha256_pkg::CHAIN_WORDS-1] <= i_var;
        end else if (i_ctl.round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    assign o_v0 = r_v[0];

endmodule

/* sim/sha256_byte_stream_hasher_tb.sv */
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_tb
// Feeds whole messages byte by byte with random content and lengths around
// the padding boundaries, and computes every digest in a scoreboard of its
// own. Each digest word is checked field by field. Both sides idle at random,
// and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
class sha256_digest_scoreboard;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_entry;

    logic [31:0]       chain [8];
    logic [7:0]        msg_block [64];
    int unsigned       fill;
    logic [63:0]       bit_count;
    t_digest_entry     digest_q [$];
    int unsigned       errors;
    int unsigned       words_checked;
    int unsigned       messages;

    function new();
        errors = 0;
        words_checked = 0;
        messages = 0;
        restart();
    endfunction

    function void restart();
        for (int i = 0; i < 8; i++) chain[i] = sha256_pkg::INIT_H[i];
        fill = 0;
        bit_count = '0;
    endfunction

    function logic [31:0] ror32(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // one 64-round compression of the block buffer into the chain
    function void compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2, e, a;
        for (int i = 0; i < 16; i++)
            w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        for (int i = 16; i < 64; i++) begin
            s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        for (int i = 0; i < 8; i++) v[i] = chain[i];
        for (int i = 0; i < 64; i++) begin
            e = v[4];
            a = v[0];
            t1 = v[7] + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25))
               + ((e & v[5]) ^ (~e & v[6])) + sha256_pkg::K_ROUND[i] + w[i];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22))
               + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = e;
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = a;
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) chain[i] += v[i];
    endfunction

    // accepted input word: append byte, pad and queue digest on end of message
    function void note_input(logic [7:0] data, logic present, logic eom);
        logic [63:0] total;
        int unsigned pos;
        t_digest_entry ent;
        if (present) begin
            msg_block[fill] = data;
            fill++;
            if (fill == 64) begin
                compress_block();
                bit_count += sha256_pkg::BLOCK_BITS;
                fill = 0;
            end
        end
        if (!eom) return;
        total = bit_count + 64'(fill) * 8;
        pos = fill;
        msg_block[pos] = sha256_pkg::PAD_MARK;
        pos++;
        if (pos > 56) begin
            while (pos < 64) begin
                msg_block[pos] = 8'h00;
                pos++;
            end
            compress_block();
            pos = 0;
        end
        while (pos < 56) begin
            msg_block[pos] = 8'h00;
            pos++;
        end
        for (int j = 0; j < 8; j++) msg_block[63-j] = total[8*j +: 8];
        compress_block();
        for (int j = 0; j < 8; j++) begin
            ent.word = chain[j];
            ent.index = 3'(j);
            ent.last = (j == 7);
            digest_q.push_back(ent);
        end
        messages++;
        restart();
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, exp);
        errors++;
    endtask

    // accepted digest word against the oldest expectation
    task check_result(logic [31:0] word, logic [2:0] index, logic last);
        t_digest_entry ent;
        if (digest_q.size() == 0) begin
            report_mismatch("unexpected digest word", word, 32'h0);
            return;
        end
        ent = digest_q.pop_front();
        words_checked++;
        if (word !== ent.word) report_mismatch("digest_word", word, ent.word);
        if (index !== ent.index) report_mismatch("word_index", 32'(index), 32'(ent.index));
        if (last !== ent.last) report_mismatch("last_word", 32'(last), 32'(ent.last));
    endtask

    function int pending();
        return digest_q.size();
    endfunction

endclass

module sha256_byte_stream_hasher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET  = 220;
    localparam int QUIET_ITEMS  = 40;
    localparam int LONG_HOLD    = 600;
    localparam int DRAIN_CYCLES = 400;
    localparam int CYCLE_LIMIT  = 400000;

    logic i_clk;
    logic i_rst_n;

    sha256_in_if  in_ch ();
    sha256_out_if out_ch ();

    sha256_byte_stream_hasher u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    sha256_digest_scoreboard digest_sb;
    int unsigned item_count;
    int unsigned cycle_count;
    bit          quiet;
    bit          long_hold_req;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // both channels sampled at the edge
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready)
            digest_sb.note_input(in_ch.data_byte, in_ch.byte_present, in_ch.end_of_message);
        if (i_rst_n && out_ch.valid && out_ch.ready)
            digest_sb.check_result(out_ch.digest_word, out_ch.word_index, out_ch.last_word);
    end

    // run watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: random ready bursts, one long hold-off on request
    initial begin
        int n;
        out_ch.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 0;
                out_ch.ready <= 1'b0;
                for (int c = 0; c < LONG_HOLD; c++) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
                n = $urandom_range(1, 19);
                repeat (n) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                n = $urandom_range(1, 20);
                repeat (n) @(posedge i_clk);
            end
        end
    end

    // one input word, with an optional idle burst ahead of it
    task send_word(logic [7:0] data, logic present, logic eom);
        int n;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            n = $urandom_range(1, 19);
            repeat (n) @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.data_byte      <= data;
        in_ch.byte_present   <= present;
        in_ch.end_of_message <= eom;
        do @(posedge i_clk); while (!in_ch.ready);
        if (present || eom) item_count++;
    endtask

    // whole message of random bytes, ended on the last byte or by an empty word
    task send_message(int len);
        bit eom_on_byte;
        eom_on_byte = (len > 0) && $urandom_range(0, 1);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) send_word(8'($urandom), 1'b0, 1'b0);
            send_word(8'($urandom), 1'b1, eom_on_byte && (i == len - 1));
        end
        if (!eom_on_byte) send_word(8'($urandom), 1'b0, 1'b1);
    endtask

    initial begin
        int edge_len [6] = '{54, 55, 56, 57, 63, 64};
        int r;
        int len;
        digest_sb = new();
        item_count = 0;
        cycle_count = 0;
        quiet = 0;
        long_hold_req = 0;
        i_rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.data_byte <= 8'h00;
        in_ch.byte_present <= 1'b0;
        in_ch.end_of_message <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty message
        send_word(8'h00, 1'b0, 1'b1);
        // "abc" with the end mark on the last byte, idle word in between
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'ha5, 1'b0, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h63, 1'b1, 1'b1);
        // extreme bytes, then an empty end word carrying junk data
        send_word(8'hff, 1'b1, 1'b0);
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'hff, 1'b0, 1'b1);
        // single byte equal to the pad mark
        send_word(8'h80, 1'b1, 1'b1);
        send_word(8'h5a, 1'b0, 1'b0);

        // random messages, receiver stalls long at the start
        long_hold_req = 1;
        while (item_count < ITEM_TARGET) begin
            if (item_count > ITEM_TARGET - QUIET_ITEMS) quiet = 1;
            r = $urandom_range(0, 9);
            if (r < 6)      len = $urandom_range(0, 12);
            else if (r < 9) len = edge_len[$urandom_range(0, 5)];
            else            len = $urandom_range(0, 130);
            // keep the run close to the item target
            if (len > int'(ITEM_TARGET - item_count)) len = int'(ITEM_TARGET - item_count);
            send_message(len);
        end
        quiet = 1;
        in_ch.valid <= 1'b0;

        while (digest_sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d input words, %0d messages hashed, %0d digest words checked",
                 item_count, digest_sb.messages, digest_sb.words_checked);
        $display("lengths around the one- and two-block padding cases, one long receiver stall");
        if (digest_sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
